[design/aatt_pkg.sv]
// ----------------------------------------------------------------------------
// aatt_pkg: shared types and constants of the acceptance temperature tuner
// Widths, fixed-point constants, register indexes and the control bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package aatt_pkg;

  // outcome window
  localparam int WINDOW_DEPTH = 32;
  localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);

  // field widths
  localparam int SCALAR_FRAC_BITS = 32;
  localparam int SCALAR_W         = 48;
  localparam int PCT_W            = 15;
  localparam int COUNT_W          = 32;
  localparam int WARMUP_W         = 8;
  localparam int CFG_LEN_W        = 6;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DESIRED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CONVERGE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SCL = CFG_IDX_W'(4);

  // reset values
  localparam logic [PCT_W-1:0]     DESIRED_RESET  = PCT_W'(8525);
  localparam logic [WARMUP_W-1:0]  WARMUP_RESET   = WARMUP_W'(6);
  localparam logic [CFG_LEN_W-1:0] ADJUST_RESET   = CFG_LEN_W'(10);
  localparam logic [CFG_LEN_W-1:0] CONVERGE_RESET = CFG_LEN_W'(30);
  localparam logic [SCALAR_W-1:0]  SCALAR_RESET   = SCALAR_W'(1) << SCALAR_FRAC_BITS;

  // fixed-point constants
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(25600);
  localparam int               GAIN_DEN = 32000;
  localparam int               CONV_TOL = 12800;

  // shared restoring divider
  localparam int DIV_NUM_W     = 64;
  localparam int DIV_DEN_W     = 16;
  localparam int DIV_CNT_W     = $clog2(DIV_NUM_W + 1);
  localparam int PCT_NUM_W     = 20;
  localparam int PCT_DIV_STEPS = PCT_NUM_W;
  localparam int SCL_DIV_STEPS = DIV_NUM_W;
  localparam int CONV_W        = 20;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic pct_load;
    logic scl_load;
    logic div_step;
    logic pct_store;
    logic scl_store;
    logic out_load;
  } aatt_cmd_t;

  typedef struct packed {
    logic adapt;
    logic scan_last;
    logic div_done;
  } aatt_sts_t;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_SCAN      = 9'b000000010,
    ST_PCT_LOAD  = 9'b000000100,
    ST_PCT_DIV   = 9'b000001000,
    ST_PCT_STORE = 9'b000010000,
    ST_SCL_LOAD  = 9'b000100000,
    ST_SCL_DIV   = 9'b001000000,
    ST_SCL_STORE = 9'b010000000,
    ST_DONE      = 9'b100000000
  } aatt_state_t;

  // window length register clamped to 1..WINDOW_DEPTH
  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > WINDOW_DEPTH) begin
      r = LEN_W'(WINDOW_DEPTH);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  // count times 25600 as shifts and adds
  function automatic logic [CONV_W-1:0] times_full(input logic [LEN_W-1:0] c);
    logic [CONV_W-1:0] w;
    w = CONV_W'(c);
    return (w << 14) + (w << 13) + (w << 10);
  endfunction

endpackage

[design/aatt_ctrl.sv]
// ----------------------------------------------------------------------------
// aatt_ctrl: sequencer of the acceptance temperature tuner
// Steps one trial through window scan, percent divide and scalar divide
// (adapting trials only) and the output register handoff.
// ----------------------------------------------------------------------------
module aatt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  aatt_pkg::aatt_sts_t sts,
  output aatt_pkg::aatt_cmd_t cmd
);

  aatt_pkg::aatt_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == aatt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      aatt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.adapt ? aatt_pkg::ST_SCAN : aatt_pkg::ST_DONE;
        end
      end
      aatt_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = aatt_pkg::ST_PCT_LOAD;
      end
      aatt_pkg::ST_PCT_LOAD: begin
        cmd.pct_load = 1'b1;
        state_nxt    = aatt_pkg::ST_PCT_DIV;
      end
      aatt_pkg::ST_PCT_DIV: begin
        if (sts.div_done) state_nxt = aatt_pkg::ST_PCT_STORE;
        else cmd.div_step = 1'b1;
      end
      aatt_pkg::ST_PCT_STORE: begin
        cmd.pct_store = 1'b1;
        state_nxt     = aatt_pkg::ST_SCL_LOAD;
      end
      aatt_pkg::ST_SCL_LOAD: begin
        cmd.scl_load = 1'b1;
        state_nxt    = aatt_pkg::ST_SCL_DIV;
      end
      aatt_pkg::ST_SCL_DIV: begin
        if (sts.div_done) state_nxt = aatt_pkg::ST_SCL_STORE;
        else cmd.div_step = 1'b1;
      end
      aatt_pkg::ST_SCL_STORE: begin
        cmd.scl_store = 1'b1;
        state_nxt     = aatt_pkg::ST_DONE;
      end
      aatt_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = aatt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aatt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aatt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/aatt_dp.sv]
// ----------------------------------------------------------------------------
// aatt_dp: datapath of the acceptance temperature tuner
// Config registers, outcome window, counters, serial window scan, shared
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module aatt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [aatt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aatt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_delta_negative,
  input  logic                                 in_trial_accepted,
  input  aatt_pkg::aatt_cmd_t                  cmd,
  output aatt_pkg::aatt_sts_t                  sts,
  output logic [aatt_pkg::SCALAR_W-1:0]        out_temperature_scalar,
  output logic [aatt_pkg::PCT_W-1:0]           out_recent_accept_pct,
  output logic                                 out_is_converged,
  output logic [aatt_pkg::COUNT_W-1:0]         out_negative_trials
);

  // configuration
  logic [aatt_pkg::PCT_W-1:0]     desired_r;
  logic [aatt_pkg::WARMUP_W-1:0]  warmup_r;
  logic [aatt_pkg::CFG_LEN_W-1:0] adjust_r;
  logic [aatt_pkg::CFG_LEN_W-1:0] converge_r;

  // tuner state
  logic [aatt_pkg::WINDOW_DEPTH-1:0] window_r;
  logic [aatt_pkg::LEN_W-1:0]        fill_r;
  logic [aatt_pkg::COUNT_W-1:0]      count_r;
  logic [aatt_pkg::SCALAR_W-1:0]     scalar_r;
  logic [aatt_pkg::PCT_W-1:0]        pct_r;
  logic                              conv_r;

  // scan and divider
  logic [aatt_pkg::WIN_IDX_W-1:0] idx_r;
  logic [aatt_pkg::LEN_W-1:0]     ones_adj_r;
  logic [aatt_pkg::LEN_W-1:0]     ones_conv_r;
  logic [aatt_pkg::DIV_NUM_W-1:0] num_r, num_nxt;
  logic [aatt_pkg::DIV_DEN_W-1:0] den_r;
  logic [aatt_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [aatt_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic [aatt_pkg::LEN_W-1:0]     clen, alen, n_len, scan_len;
  logic [aatt_pkg::PCT_W-1:0]     des;
  logic [aatt_pkg::COUNT_W-1:0]   count_inc;
  logic [aatt_pkg::LEN_W-1:0]     fill_upd;
  logic                           bit_sel;
  logic [aatt_pkg::PCT_NUM_W-1:0] pct_num;
  logic [aatt_pkg::DIV_DEN_W:0]   rem_sh;
  logic                           rem_ge;
  logic [aatt_pkg::DIV_DEN_W:0]   den_full;
  logic [aatt_pkg::DIV_NUM_W-1:0] scl_ext, scl_num;
  logic [aatt_pkg::SCALAR_W-1:0]  scl_q;
  logic [aatt_pkg::CONV_W-1:0]    conv_have, conv_want, conv_diff;

  assign clen  = aatt_pkg::clamp_len(converge_r);
  assign alen  = aatt_pkg::clamp_len(adjust_r);
  assign des   = (desired_r > aatt_pkg::PCT_FULL) ? aatt_pkg::PCT_FULL : desired_r;
  assign n_len = (fill_r < alen) ? fill_r : alen;
  assign scan_len = (n_len > clen) ? n_len : clen;

  // saturating count and fill as they stand after this trial
  assign count_inc = (&count_r) ? count_r : count_r + aatt_pkg::COUNT_W'(1);
  assign fill_upd  = (fill_r > clen - aatt_pkg::LEN_W'(1)) ? clen
                                                           : fill_r + aatt_pkg::LEN_W'(1);

  assign sts.adapt     = in_delta_negative &&
                         (count_inc >= aatt_pkg::COUNT_W'(warmup_r));
  assign sts.scan_last = (aatt_pkg::LEN_W'(idx_r) == scan_len - aatt_pkg::LEN_W'(1));
  assign sts.div_done  = (div_cnt_r == '0);

  assign bit_sel = window_r[idx_r];

  // restoring divide step
  assign rem_sh  = {rem_r, num_r[aatt_pkg::DIV_NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = rem_ge ? aatt_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                          : aatt_pkg::DIV_DEN_W'(rem_sh);
  assign num_nxt = {num_r[aatt_pkg::DIV_NUM_W-2:0], rem_ge};

  // ones * 25600 + n / 2
  assign pct_num = aatt_pkg::times_full(ones_adj_r) +
                   aatt_pkg::PCT_NUM_W'(n_len >> 1);

  // den = 32000 + pct - desired, always within 6400..57600
  assign den_full = (aatt_pkg::DIV_DEN_W+1)'(aatt_pkg::GAIN_DEN) +
                    (aatt_pkg::DIV_DEN_W+1)'(pct_r) - (aatt_pkg::DIV_DEN_W+1)'(des);
  // scalar * 32000 as (s << 15) - (s << 9) - (s << 8), plus den / 2
  assign scl_ext = aatt_pkg::DIV_NUM_W'(scalar_r);
  assign scl_num = (scl_ext << 15) - (scl_ext << 9) - (scl_ext << 8) +
                   aatt_pkg::DIV_NUM_W'(den_full >> 1);

  // saturate to 48 bits, clamp to one lsb
  always_comb begin
    if (|num_r[aatt_pkg::DIV_NUM_W-1:aatt_pkg::SCALAR_W]) begin
      scl_q = '1;
    end else if (num_r[aatt_pkg::SCALAR_W-1:0] == '0) begin
      scl_q = aatt_pkg::SCALAR_W'(1);
    end else begin
      scl_q = num_r[aatt_pkg::SCALAR_W-1:0];
    end
  end

  // convergence distance |ones*25600 - desired*len|
  assign conv_have = aatt_pkg::times_full(ones_conv_r);
  assign conv_want = aatt_pkg::CONV_W'(des) * aatt_pkg::CONV_W'(clen);
  assign conv_diff = (conv_have >= conv_want) ? conv_have - conv_want
                                              : conv_want - conv_have;

  // configuration and tuner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r  <= aatt_pkg::DESIRED_RESET;
      warmup_r   <= aatt_pkg::WARMUP_RESET;
      adjust_r   <= aatt_pkg::ADJUST_RESET;
      converge_r <= aatt_pkg::CONVERGE_RESET;
      window_r   <= '0;
      fill_r     <= '0;
      count_r    <= '0;
      scalar_r   <= aatt_pkg::SCALAR_RESET;
      pct_r      <= '0;
      conv_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aatt_pkg::REG_DESIRED:  desired_r  <= cfg_wdata[aatt_pkg::PCT_W-1:0];
          aatt_pkg::REG_WARMUP:   warmup_r   <= cfg_wdata[aatt_pkg::WARMUP_W-1:0];
          aatt_pkg::REG_ADJUST:   adjust_r   <= cfg_wdata[aatt_pkg::CFG_LEN_W-1:0];
          aatt_pkg::REG_CONVERGE: converge_r <= cfg_wdata[aatt_pkg::CFG_LEN_W-1:0];
          aatt_pkg::REG_INIT_SCL: begin
            scalar_r <= (cfg_wdata[aatt_pkg::SCALAR_W-1:0] == '0)
                        ? aatt_pkg::SCALAR_W'(1) : cfg_wdata[aatt_pkg::SCALAR_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.accept && in_delta_negative) begin
        count_r  <= count_inc;
        window_r <= {window_r[aatt_pkg::WINDOW_DEPTH-2:0], in_trial_accepted};
        fill_r   <= fill_upd;
        if (!sts.adapt) conv_r <= 1'b0;
      end
      if (cmd.pct_store) begin
        pct_r <= num_r[aatt_pkg::PCT_W-1:0];
        if (fill_r == clen && conv_diff <= aatt_pkg::CONV_W'(aatt_pkg::CONV_TOL)) begin
          conv_r <= 1'b1;
        end
      end
      if (cmd.scl_store) scalar_r <= scl_q;
    end
  end

  // window scan and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ones_adj_r  <= '0;
      ones_conv_r <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (cmd.accept) begin
        idx_r       <= '0;
        ones_adj_r  <= '0;
        ones_conv_r <= '0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + aatt_pkg::WIN_IDX_W'(1);
        if (bit_sel && aatt_pkg::LEN_W'(idx_r) < n_len) begin
          ones_adj_r <= ones_adj_r + aatt_pkg::LEN_W'(1);
        end
        if (bit_sel && aatt_pkg::LEN_W'(idx_r) < clen) begin
          ones_conv_r <= ones_conv_r + aatt_pkg::LEN_W'(1);
        end
      end
      if (cmd.pct_load) begin
        div_cnt_r <= aatt_pkg::DIV_CNT_W'(aatt_pkg::PCT_DIV_STEPS);
      end else if (cmd.scl_load) begin
        div_cnt_r <= aatt_pkg::DIV_CNT_W'(aatt_pkg::SCL_DIV_STEPS);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - aatt_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pct_load) begin
      num_r <= {pct_num, (aatt_pkg::DIV_NUM_W-aatt_pkg::PCT_NUM_W)'(0)};
      den_r <= aatt_pkg::DIV_DEN_W'(n_len);
      rem_r <= '0;
    end else if (cmd.scl_load) begin
      num_r <= scl_num;
      den_r <= aatt_pkg::DIV_DEN_W'(den_full);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_temperature_scalar <= scalar_r;
      out_recent_accept_pct  <= pct_r;
      out_is_converged       <= conv_r;
      out_negative_trials    <= count_r;
    end
  end

endmodule

[design/adaptive_acceptance_temperature_tuner.sv]
// ----------------------------------------------------------------------------
// adaptive_acceptance_temperature_tuner: acceptance-rate temperature tuner
// Tracks Metropolis trial outcomes and adapts a Q16.32 temperature scalar.
// ----------------------------------------------------------------------------
// usage
//   in channel: one beat per trial (delta_negative, trial_accepted), in_ready
//     is high while the sequencer is idle
//   out channel: one beat per trial with scalar, recent percent, converged
//     flag and saturating negative trial count, held in an output register
//   cfg port: cfg_we/cfg_index/cfg_wdata, write only while the block is idle;
//     writing initial_scalar reloads the scalar at once
//   sequence: a non-negative or pre-warm-up trial goes from acceptance
//     straight to the output register; an adapting trial first scans L
//     window bits, L being the larger of the averaged length and the
//     converge length (1..32), then runs the percent and scalar divides
//   throughput: one trial at a time; the time is set by the serial window
//     scan (one bit a cycle) and the shared restoring divider (one quotient
//     bit a cycle: 20 steps for the percent, 64 for the scalar)
//   stall: the next trial is taken while a result waits in the output
//     register; the sequencer holds in its final state until the slot frees
//   reset: synchronous active-low rst_n restores register defaults, empties
//     the window and sets the scalar to 1.0
// ----------------------------------------------------------------------------
module adaptive_acceptance_temperature_tuner (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [aatt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aatt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // trial input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_delta_negative,
  input  logic                            in_trial_accepted,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [aatt_pkg::SCALAR_W-1:0]   out_temperature_scalar,
  output logic [aatt_pkg::PCT_W-1:0]      out_recent_accept_pct,
  output logic                            out_is_converged,
  output logic [aatt_pkg::COUNT_W-1:0]    out_negative_trials
);

  aatt_pkg::aatt_cmd_t cmd;
  aatt_pkg::aatt_sts_t sts;

  // sequencer: walks a trial through scan, two divides (adapting trials only) and the output slot
  aatt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: window, counters, divider and output register
  aatt_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_delta_negative      (in_delta_negative),
    .in_trial_accepted      (in_trial_accepted),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_temperature_scalar (out_temperature_scalar),
    .out_recent_accept_pct  (out_recent_accept_pct),
    .out_is_converged       (out_is_converged),
    .out_negative_trials    (out_negative_trials)
  );

`ifndef SYNTH
  // the scalar is clamped to one lsb, never zero
  a_scalar_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_scalar != '0))
    else $error("temperature scalar reached zero");

  // percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_recent_accept_pct <= aatt_pkg::PCT_FULL))
    else $error("recent percent above full scale");

  // one trial at a time: the beat just taken blocks the next
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second trial taken while one is in flight");
`endif

endmodule
